### hdl/websocket_frame_receiver_assert.svh
// Assertion macros for the WebSocket frame receiver.
`ifndef WEBSOCKET_FRAME_RECEIVER_ASSERT_SVH
`define WEBSOCKET_FRAME_RECEIVER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define WSFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wsfr assertion failed");
// Next-cycle implication, checked out of reset.
`define WSFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wsfr assertion failed");
`else
`define WSFR_ASSERT_NOW(label, ante, cons)
`define WSFR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hdl/wsfr_pkg.sv
// Types and codes shared by the WebSocket frame receiver.
package wsfr_pkg;

  localparam int DEF_SOCKETS = 8;
  localparam int MAX_SOCKETS = 8;   // reach of the 3-bit socket number

  localparam logic [1:0] FN_BYTE      = 2'd0;
  localparam logic [1:0] FN_HANDSHAKE = 2'd1;
  localparam logic [1:0] FN_RESET     = 2'd2;

  localparam logic [2:0] K_NONE      = 3'd0;
  localparam logic [2:0] K_PAYLOAD   = 3'd1;
  localparam logic [2:0] K_HANDSHAKE = 3'd2;
  localparam logic [2:0] K_ERROR     = 3'd3;
  localparam logic [2:0] K_CLOSE     = 3'd4;

  localparam logic [3:0] OP_CONT   = 4'd0;
  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_CLOSE  = 4'd8;
  localparam logic [3:0] OP_PING   = 4'd9;
  localparam logic [3:0] OP_PONG   = 4'd10;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [2:0] HDR_LAST  = 3'd5;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] socket_id;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] out_socket;
    logic [7:0] data_byte;
    logic       last_of_frame;
  } out_item_t;

endpackage

### hdl/websocket_frame_receiver.sv
// WebSocket receive deframer: per-socket header parse, checks and payload unmasking.
// An accepted item is registered in the input stage, and its result in the output register that drives out_valid.
// Takes one item per cycle unless out_stall holds a result; socket state is read, updated and written back per item.
// Back-to-back items on the same socket see the state written by the one before.
// Reset (rst_n low, synchronous) clears every socket to wait-for-handshake and empties both stages.
`include "websocket_frame_receiver_assert.svh"

module websocket_frame_receiver
  import wsfr_pkg::*;
#(
  parameter int SOCKETS = DEF_SOCKETS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int DEPTH = (SOCKETS > MAX_SOCKETS) ? MAX_SOCKETS : SOCKETS;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_DEAD    = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  hcnt;
    logic [3:0]  opcode;
    logic        mask;
    logic [31:0] key;
    logic [6:0]  remaining;
    logic [1:0]  kidx;
  } sock_st_t;

  // Pipeline registers
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  sock_st_t  sock_r [DEPTH];

  logic      out_free;
  logic      s1_go;
  logic      in_range;
  logic [IDX_W-1:0] idx;
  sock_st_t  st;
  sock_st_t  st_nxt;
  out_item_t res_nxt;
  logic [1:0] ksel;
  logic [6:0] rem_dec;

  // Handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Socket select
  assign in_range = (int'(s1_item_r.socket_id) < SOCKETS);
  assign idx      = IDX_W'({1'b0, s1_item_r.socket_id});
  assign st       = in_range ? sock_r[idx] : '0;

  // Per-item state update and result
  always_comb begin
    st_nxt  = st;
    res_nxt = '0;
    res_nxt.out_socket = s1_item_r.socket_id;
    ksel    = 2'(st.hcnt - 3'd2);
    rem_dec = st.remaining - 7'd1;
    if (in_range) begin
      case (s1_item_r.func)
        FN_RESET: begin
          st_nxt = '0;
        end
        FN_HANDSHAKE: begin
          if (st.phase == PH_WAIT) begin
            st_nxt.phase = PH_HEADER;
            st_nxt.hcnt  = '0;
          end
        end
        FN_BYTE: begin
          case (st.phase)
            PH_WAIT: begin
              res_nxt.kind      = K_HANDSHAKE;
              res_nxt.data_byte = s1_item_r.rx_byte;
            end
            PH_HEADER: begin
              // collect header field
              if (st.hcnt == 3'd0) begin
                st_nxt.opcode = s1_item_r.rx_byte[3:0];
              end else if (st.hcnt == 3'd1) begin
                st_nxt.mask      = s1_item_r.rx_byte[7];
                st_nxt.remaining = s1_item_r.rx_byte[6:0];
              end else begin
                st_nxt.key[ksel*8 +: 8] = s1_item_r.rx_byte;
              end
              // header complete: run checks in priority order
              if (st.hcnt >= HDR_LAST) begin
                st_nxt.hcnt = '0;
                if (!st_nxt.mask || st_nxt.remaining == LEN_EXT16
                    || st_nxt.remaining == LEN_EXT64) begin
                  st_nxt.phase = PH_DEAD;
                  res_nxt.kind = K_ERROR;
                end else if (st_nxt.opcode == OP_CONT || st_nxt.opcode == OP_TEXT
                    || st_nxt.opcode == OP_PING || st_nxt.opcode == OP_PONG) begin
                  st_nxt.phase = PH_DEAD;
                  res_nxt.kind = K_ERROR;
                end else if (st_nxt.opcode == OP_CLOSE) begin
                  st_nxt.phase = PH_DEAD;
                  res_nxt.kind = K_CLOSE;
                end else if (st_nxt.opcode == OP_BINARY && st_nxt.remaining != '0) begin
                  st_nxt.phase = PH_PAYLOAD;
                  st_nxt.kidx  = '0;
                end else begin
                  st_nxt.phase = PH_HEADER;
                end
              end else begin
                st_nxt.hcnt = st.hcnt + 3'd1;
              end
            end
            PH_PAYLOAD: begin
              // unmask with rotating key byte
              res_nxt.kind      = K_PAYLOAD;
              res_nxt.data_byte = s1_item_r.rx_byte ^ st.key[st.kidx*8 +: 8];
              st_nxt.kidx       = st.kidx + 2'd1;
              st_nxt.remaining  = rem_dec;
              if (rem_dec == '0) begin
                res_nxt.last_of_frame = 1'b1;
                st_nxt.phase          = PH_HEADER;
                st_nxt.hcnt           = '0;
              end
            end
            default: begin
              // dead socket drops bytes
            end
          endcase
        end
        default: begin
          // unused command
        end
      endcase
    end
  end

  // Input and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
    if (s1_go) begin
      out_item_r <= res_nxt;
    end
  end

  // Per-socket state
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (!rst_n) begin
        sock_r[i] <= '0;
      end else if (s1_go && in_range && idx == IDX_W'(i)) begin
        sock_r[i] <= st_nxt;
      end
    end
  end

  // Checks
  `WSFR_ASSERT_NEXT(a_accept_loads, in_valid && !in_stall, s1_valid_r)
  `WSFR_ASSERT_NOW(a_hcnt_bound, s1_valid_r && in_range, st.hcnt <= HDR_LAST)
  `WSFR_ASSERT_NOW(a_payload_nonzero, s1_valid_r && in_range && st.phase == PH_PAYLOAD,
                   st.remaining != '0)

endmodule

### tb/sv/websocket_frame_receiver_test.sv
// Self-checking testbench for the WebSocket frame receiver: directed frames, then random traffic.
module websocket_frame_receiver_test
  import wsfr_pkg::*;
();

  localparam int SOCK_N = DEF_SOCKETS;
  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 60;

  typedef enum logic [1:0] {SP_WAIT, SP_HEADER, SP_PAYLOAD, SP_DEAD} sock_phase_e;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Per-socket shadow state of the deframer
  sock_phase_e sock_phase   [SOCK_N];
  logic [2:0]  hdr_seen     [SOCK_N];
  logic [3:0]  frame_op     [SOCK_N];
  logic        frame_masked [SOCK_N];
  logic [31:0] mask_key     [SOCK_N];
  logic [6:0]  bytes_left   [SOCK_N];
  logic [1:0]  key_sel      [SOCK_N];

  // Results still owed by the block, oldest first
  out_item_t deframed_q [$];
  // Planned byte streams, one per socket
  in_item_t  plan_q [SOCK_N][$];

  int fail_count = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  websocket_frame_receiver #(.SOCKETS(SOCK_N)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("websocket_frame_receiver_test failed");
    $finish;
  end

  function automatic void clear_socket(int s);
    sock_phase[s]   = SP_WAIT;
    hdr_seen[s]     = '0;
    frame_op[s]     = '0;
    frame_masked[s] = 1'b0;
    mask_key[s]     = '0;
    bytes_left[s]   = '0;
    key_sel[s]      = '0;
  endfunction

  // Advance one socket by one item and return the result it produces
  function automatic out_item_t deframe_item(in_item_t it);
    out_item_t r;
    int s;
    int n;
    r = '0;
    r.out_socket = it.socket_id;
    s = it.socket_id;
    if (s < SOCK_N) begin
      case (it.func)
        FN_RESET: clear_socket(s);
        FN_HANDSHAKE: begin
          if (sock_phase[s] == SP_WAIT) begin
            sock_phase[s] = SP_HEADER;
            hdr_seen[s] = '0;
          end
        end
        FN_BYTE: begin
          case (sock_phase[s])
            SP_WAIT: begin
              r.kind = K_HANDSHAKE;
              r.data_byte = it.rx_byte;
            end
            SP_HEADER: begin
              n = hdr_seen[s];
              if (n == 0) frame_op[s] = it.rx_byte[3:0];
              else if (n == 1) begin
                frame_masked[s] = it.rx_byte[7];
                bytes_left[s] = it.rx_byte[6:0];
              end else mask_key[s][8*(n-2) +: 8] = it.rx_byte;
              if (n >= HDR_LAST) begin
                // header complete: checks in priority order
                hdr_seen[s] = '0;
                if (!frame_masked[s] || bytes_left[s] == LEN_EXT16 ||
                    bytes_left[s] == LEN_EXT64) begin
                  sock_phase[s] = SP_DEAD;
                  r.kind = K_ERROR;
                end else if (frame_op[s] == OP_CONT || frame_op[s] == OP_TEXT ||
                             frame_op[s] == OP_PING || frame_op[s] == OP_PONG) begin
                  sock_phase[s] = SP_DEAD;
                  r.kind = K_ERROR;
                end else if (frame_op[s] == OP_CLOSE) begin
                  sock_phase[s] = SP_DEAD;
                  r.kind = K_CLOSE;
                end else if (frame_op[s] == OP_BINARY && bytes_left[s] != 0) begin
                  sock_phase[s] = SP_PAYLOAD;
                  key_sel[s] = '0;
                end else sock_phase[s] = SP_HEADER;
              end else hdr_seen[s] = 3'(n + 1);
            end
            SP_PAYLOAD: begin
              r.kind = K_PAYLOAD;
              r.data_byte = it.rx_byte ^ mask_key[s][8*key_sel[s] +: 8];
              key_sel[s] = key_sel[s] + 2'd1;
              bytes_left[s] = bytes_left[s] - 7'd1;
              if (bytes_left[s] == 0) begin
                r.last_of_frame = 1'b1;
                sock_phase[s] = SP_HEADER;
                hdr_seen[s] = '0;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic in_item_t mk(logic [1:0] f, int s, logic [7:0] b);
    in_item_t it;
    it.func = f;
    it.socket_id = 3'(s);
    it.rx_byte = b;
    return it;
  endfunction

  // Queue the next stretch of traffic for a socket, malformed headers included
  task automatic plan_segment(int s);
    int pick;
    logic [3:0] op;
    logic [6:0] len;
    logic masked;
    case (sock_phase[s])
      SP_WAIT: begin
        repeat ($urandom_range(3)) plan_q[s].push_back(mk(FN_BYTE, s, 8'($urandom)));
        plan_q[s].push_back(mk(($urandom_range(9) == 0) ? FN_RESET : FN_HANDSHAKE, s,
                               8'($urandom)));
      end
      SP_DEAD: begin
        if ($urandom_range(2) == 0) plan_q[s].push_back(mk(FN_BYTE, s, 8'($urandom)));
        if ($urandom_range(4) == 0) plan_q[s].push_back(mk(FN_HANDSHAKE, s, 8'($urandom)));
        plan_q[s].push_back(mk(FN_RESET, s, 8'($urandom)));
      end
      SP_PAYLOAD: begin
        repeat (bytes_left[s]) plan_q[s].push_back(mk(FN_BYTE, s, 8'($urandom)));
      end
      default: begin
        if ($urandom_range(29) == 0) plan_q[s].push_back(mk(FN_RESET, s, 8'($urandom)));
        else begin
          pick = $urandom_range(99);
          masked = 1'b1;
          len = 7'($urandom_range(125));
          if (pick < 55) begin
            // binary, mostly short payloads
            op = OP_BINARY;
            len = ($urandom_range(9) == 0) ? 7'($urandom_range(125)) : 7'($urandom_range(8));
          end else if (pick < 63) begin
            // reserved opcode
            do op = 4'($urandom_range(15));
            while (op == OP_CONT || op == OP_TEXT || op == OP_BINARY ||
                   op == OP_CLOSE || op == OP_PING || op == OP_PONG);
          end else if (pick < 70) op = OP_CLOSE;
          else if (pick < 78) begin
            // mask bit clear
            masked = 1'b0;
            op = 4'($urandom_range(15));
            len = 7'($urandom_range(127));
          end else if (pick < 86) begin
            // extended length forms
            op = 4'($urandom_range(15));
            len = ($urandom_range(1) == 0) ? LEN_EXT16 : LEN_EXT64;
          end else begin
            case ($urandom_range(3))
              0: op = OP_CONT;
              1: op = OP_TEXT;
              2: op = OP_PING;
              default: op = OP_PONG;
            endcase
          end
          plan_q[s].push_back(mk(FN_BYTE, s, {4'($urandom_range(15)), op}));
          plan_q[s].push_back(mk(FN_BYTE, s, {masked, len}));
          repeat (4) plan_q[s].push_back(mk(FN_BYTE, s, 8'($urandom)));
          if (pick < 55) repeat (len) plan_q[s].push_back(mk(FN_BYTE, s, 8'($urandom)));
        end
      end
    endcase
  endtask

  // Mostly planned traffic on a random socket, some noise items
  task automatic next_random_item(output in_item_t it);
    int s;
    s = $urandom_range(SOCK_N - 1);
    if ($urandom_range(99) < 4) it = mk(2'($urandom_range(3)), s, 8'($urandom));
    else begin
      if (plan_q[s].size() == 0) plan_segment(s);
      it = plan_q[s].pop_front();
    end
  endtask

  // Offer one item from a falling edge; returns at the falling edge after acceptance
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframed_q.push_back(deframe_item(it));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (deframed_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_idling(int src_pct, int snk_pct);
    @(posedge clk);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    @(negedge clk);
  endtask

  // Handshake bytes pass through; unused command and repeated accept are ignored
  task automatic test_handshake_phase();
    send_item(mk(FN_BYTE, 0, 8'h00));
    send_item(mk(FN_BYTE, 0, 8'hFF));
    send_item(mk(FN_UNUSED, 0, 8'hFF));
    send_item(mk(FN_HANDSHAKE, 0, 8'h00));
    send_item(mk(FN_HANDSHAKE, 0, 8'h00));
  endtask

  // Two-byte binary frame with a key of mixed extremes
  task automatic test_binary_frame();
    send_item(mk(FN_BYTE, 0, {4'b1000, OP_BINARY}));
    send_item(mk(FN_BYTE, 0, {1'b1, 7'd2}));
    send_item(mk(FN_BYTE, 0, 8'hA5));
    send_item(mk(FN_BYTE, 0, 8'h5A));
    send_item(mk(FN_BYTE, 0, 8'hFF));
    send_item(mk(FN_BYTE, 0, 8'h00));
    send_item(mk(FN_BYTE, 0, 8'hFF));
    send_item(mk(FN_BYTE, 0, 8'h00));
  endtask

  // Close frame kills the socket until a reset brings it back to handshake
  task automatic test_close_and_dead();
    send_item(mk(FN_HANDSHAKE, 7, 8'h00));
    send_item(mk(FN_BYTE, 7, {4'b1111, OP_CLOSE}));
    send_item(mk(FN_BYTE, 7, {1'b1, 7'd0}));
    repeat (4) send_item(mk(FN_BYTE, 7, 8'($urandom)));
    send_item(mk(FN_BYTE, 7, 8'h55));
    send_item(mk(FN_HANDSHAKE, 7, 8'h00));
    send_item(mk(FN_RESET, 7, 8'h00));
    send_item(mk(FN_BYTE, 7, 8'h33));
  endtask

  task automatic test_random_traffic(int count);
    in_item_t it;
    repeat (count) begin
      next_random_item(it);
      send_item(it);
    end
  endtask

  // Long receiver hold-off while items keep coming, so the input stalls
  task automatic test_backpressure();
    in_valid <= 1'b0;
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    test_random_traffic(40);
    wait_drained();
  endtask

  // Receiver side: stall at random, or for a long stretch on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else out_stall <= ($urandom_range(99) < snk_idle_pct);
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (deframed_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
      end else begin
        want = deframed_q.pop_front();
        check_field("kind", want.kind, out_item.kind);
        check_field("out_socket", want.out_socket, out_item.out_socket);
        check_field("data_byte", want.data_byte, out_item.data_byte);
        check_field("last_of_frame", want.last_of_frame, out_item.last_of_frame);
      end
    end
  end

  initial begin
    for (int s = 0; s < SOCK_N; s++) clear_socket(s);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_handshake_phase();
    test_binary_frame();
    test_close_and_dead();
    wait_drained();

    set_idling(9, 69);
    test_random_traffic(370);
    wait_drained();

    set_idling(69, 9);
    test_random_traffic(370);
    wait_drained();

    set_idling(0, 0);
    test_backpressure();
    test_random_traffic(300);
    wait_drained();

    repeat (8) @(negedge clk);
    if (fail_count == 0 && deframed_q.size() == 0)
      $display("websocket_frame_receiver_test passed");
    else
      $display("websocket_frame_receiver_test failed");
    $finish;
  end

endmodule

### websocket_frame_receiver.f
+incdir+hdl
hdl/wsfr_pkg.sv
hdl/websocket_frame_receiver.sv
tb/sv/websocket_frame_receiver_test.sv
